// ===== rtl/core/cis_pkg.sv =====
// Shared types and constants of the instruction step block.
package cis_pkg;

	// One instruction request: opcode, immediate bytes and the byte read from memory.
	typedef struct packed {
		logic [7:0] opcode;
		logic [7:0] imm_lo;
		logic [7:0] imm_hi;
		logic [7:0] mem_read_data;
	} instr_t;

	// One result: registers after the instruction, memory access and cost.
	typedef struct packed {
		logic [15:0] pc;
		logic [15:0] sp;
		logic [7:0]  acc;
		logic [3:0]  flags;
		logic [15:0] pair_bc;
		logic [15:0] pair_de;
		logic [15:0] pair_hl;
		logic        halted_stop;
		logic [1:0]  mem_write_kind;
		logic [15:0] mem_addr;
		logic [15:0] mem_write_data;
		logic [4:0]  cycle_cost;
	} result_t;

	// Architectural state of the core.
	typedef struct packed {
		logic [15:0] pc;
		logic [15:0] sp;
		logic [7:0]  acc;
		logic [3:0]  flags;
		logic [15:0] bc;
		logic [15:0] de;
		logic [15:0] hl;
		logic        stopped;
	} arch_state_t;

	// Flag bit positions.
	localparam int unsigned FLAG_Z = 3;
	localparam int unsigned FLAG_N = 2;
	localparam int unsigned FLAG_H = 1;
	localparam int unsigned FLAG_C = 0;

	// Memory access kinds.
	localparam logic [1:0] MEM_NONE = 2'd0;
	localparam logic [1:0] MEM_BYTE = 2'd1;
	localparam logic [1:0] MEM_WORD = 2'd2;

	// Cycle costs.
	localparam logic [4:0] COST_0  = 5'd0;
	localparam logic [4:0] COST_4  = 5'd4;
	localparam logic [4:0] COST_8  = 5'd8;
	localparam logic [4:0] COST_12 = 5'd12;
	localparam logic [4:0] COST_20 = 5'd20;

	// Miscellaneous column, opcode bits 4:3 with bit 5 clear.
	localparam logic [1:0] MISC_NOP      = 2'd0;
	localparam logic [1:0] MISC_LD_NN_SP = 2'd1;
	localparam logic [1:0] MISC_STOP     = 2'd2;
	localparam logic [1:0] MISC_JR       = 2'd3;

	// Jump conditions, opcode bits 4:3.
	localparam logic [1:0] COND_NZ = 2'd0;
	localparam logic [1:0] COND_Z  = 2'd1;
	localparam logic [1:0] COND_NC = 2'd2;
	localparam logic [1:0] COND_C  = 2'd3;

	// Register pair select, opcode bits 5:4. In the indirect loads HL and SP codes
	// stand for (HL+) and (HL-).
	localparam logic [1:0] PAIR_BC = 2'd0;
	localparam logic [1:0] PAIR_DE = 2'd1;
	localparam logic [1:0] PAIR_HL = 2'd2;
	localparam logic [1:0] PAIR_SP = 2'd3;

	// 16-bit column, opcode bits 3:0.
	localparam logic [3:0] LO_LD_RR_NN  = 4'h1;
	localparam logic [3:0] LO_LD_IND_A  = 4'h2;
	localparam logic [3:0] LO_INC_RR    = 4'h3;
	localparam logic [3:0] LO_ADD_HL_RR = 4'h9;
	localparam logic [3:0] LO_LD_A_IND  = 4'hA;

	// 8-bit column, opcode bits 1:0.
	localparam logic [1:0] R8OP_INC  = 2'd0;
	localparam logic [1:0] R8OP_DEC  = 2'd1;
	localparam logic [1:0] R8OP_LD_N = 2'd2;

	// 8-bit register index, opcode bits 5:3.
	localparam logic [2:0] R8_B   = 3'd0;
	localparam logic [2:0] R8_C   = 3'd1;
	localparam logic [2:0] R8_D   = 3'd2;
	localparam logic [2:0] R8_E   = 3'd3;
	localparam logic [2:0] R8_H   = 3'd4;
	localparam logic [2:0] R8_L   = 3'd5;
	localparam logic [2:0] R8_MEM = 3'd6;
	localparam logic [2:0] R8_A   = 3'd7;

	// Accumulator and flag operations, opcode bits 5:3.
	localparam logic [2:0] ROT_RLCA = 3'd0;
	localparam logic [2:0] ROT_RRCA = 3'd1;
	localparam logic [2:0] ROT_RLA  = 3'd2;
	localparam logic [2:0] ROT_RRA  = 3'd3;
	localparam logic [2:0] ROT_DAA  = 3'd4;
	localparam logic [2:0] ROT_CPL  = 3'd5;
	localparam logic [2:0] ROT_SCF  = 3'd6;
	localparam logic [2:0] ROT_CCF  = 3'd7;

endpackage

// ===== rtl/core/cis_exec.sv =====
// Execute unit: next architectural state and result of one instruction.
module cis_exec
	import cis_pkg::*;
(
	input  arch_state_t cur,
	input  instr_t      instr,
	output arch_state_t nxt,
	output result_t     result
);

	logic [7:0]  op;
	logic [15:0] nn;
	logic [15:0] disp;
	logic [1:0]  sel;
	logic [2:0]  dst;
	logic [15:0] pc_p1, pc_p2, pc_p3, pc_jr;
	logic [15:0] ptr;
	logic        cond_ok;

	logic [15:0] pc_n;
	logic [1:0]  kind;
	logic [15:0] addr;
	logic [15:0] wdata;
	logic [4:0]  cost;
	logic [15:0] pair_val;
	logic        pair_we;
	logic [15:0] pair_new;
	logic        r8_we;
	logic [7:0]  r8_new;
	logic [7:0]  pre;
	logic [7:0]  post;
	logic [16:0] sum_full;
	logic [12:0] sum_half;
	logic        half;

	assign op    = instr.opcode;
	assign nn    = {instr.imm_hi, instr.imm_lo};
	assign disp  = {{8{instr.imm_lo[7]}}, instr.imm_lo};
	assign sel   = op[5:4];
	assign dst   = op[5:3];
	assign pc_p1 = cur.pc + 16'd1;
	assign pc_p2 = cur.pc + 16'd2;
	assign pc_p3 = cur.pc + 16'd3;
	assign pc_jr = pc_p2 + disp;
	assign ptr   = (sel == PAIR_BC) ? cur.bc : (sel == PAIR_DE) ? cur.de : cur.hl;

	always_comb begin
		case (op[4:3])
			COND_NZ: cond_ok = !cur.flags[FLAG_Z];
			COND_Z:  cond_ok = cur.flags[FLAG_Z];
			COND_NC: cond_ok = !cur.flags[FLAG_C];
			default: cond_ok = cur.flags[FLAG_C];
		endcase
	end

	always_comb begin
		case (sel)
			PAIR_BC: pair_val = cur.bc;
			PAIR_DE: pair_val = cur.de;
			PAIR_HL: pair_val = cur.hl;
			default: pair_val = cur.sp;
		endcase
	end

	always_comb begin
		case (dst)
			R8_B:    pre = cur.bc[15:8];
			R8_C:    pre = cur.bc[7:0];
			R8_D:    pre = cur.de[15:8];
			R8_E:    pre = cur.de[7:0];
			R8_H:    pre = cur.hl[15:8];
			R8_L:    pre = cur.hl[7:0];
			R8_A:    pre = cur.acc;
			default: pre = instr.mem_read_data;
		endcase
	end

	assign post     = op[0] ? (pre - 8'd1) : (pre + 8'd1);
	assign sum_full = {1'b0, cur.hl} + {1'b0, pair_val};
	assign sum_half = {1'b0, cur.hl[11:0]} + {1'b0, pair_val[11:0]};
	// half carry of INC/DEC: borrow out of or carry into bit 4
	assign half     = op[0] ? (pre[3:0] == 4'h0) : (pre[3:0] == 4'hF);

	always_comb begin
		nxt      = cur;
		kind     = MEM_NONE;
		addr     = '0;
		wdata    = '0;
		cost     = COST_0;
		pc_n     = cur.pc;
		pair_we  = 1'b0;
		pair_new = '0;
		r8_we    = 1'b0;
		r8_new   = '0;
		if (!cur.stopped) begin
			cost = COST_4;
			pc_n = pc_p1;
			if (op[7:6] != 2'b00) begin
				// outside the first quarter: plain one-byte no-op
				pc_n = pc_p1;
			end else if (op[2:0] == 3'b000) begin
				if (!op[5]) begin
					case (op[4:3])
						MISC_NOP: pc_n = pc_p1;
						MISC_LD_NN_SP: begin
							pc_n  = pc_p3;
							cost  = COST_20;
							kind  = MEM_WORD;
							addr  = nn;
							wdata = cur.sp;
						end
						MISC_STOP: begin
							pc_n        = pc_p2;
							nxt.stopped = 1'b1;
						end
						default: begin
							pc_n = pc_jr;
							cost = COST_12;
						end
					endcase
				end else begin
					pc_n = pc_p2;
					cost = COST_8;
					if (cond_ok) begin
						pc_n = pc_jr;
						cost = COST_12;
					end
				end
			end else if (!op[2]) begin
				cost = COST_8;
				case (op[3:0])
					LO_LD_RR_NN: begin
						pc_n     = pc_p3;
						cost     = COST_12;
						pair_we  = 1'b1;
						pair_new = nn;
					end
					LO_ADD_HL_RR: begin
						nxt.hl = sum_full[15:0];
						nxt.flags = {cur.flags[FLAG_Z], 1'b0, sum_half[12], sum_full[16]};
					end
					LO_LD_IND_A: begin
						kind  = MEM_BYTE;
						addr  = ptr;
						wdata = {8'h00, cur.acc};
						if (sel == PAIR_HL) nxt.hl = cur.hl + 16'd1;
						if (sel == PAIR_SP) nxt.hl = cur.hl - 16'd1;
					end
					LO_LD_A_IND: begin
						addr    = ptr;
						nxt.acc = instr.mem_read_data;
						if (sel == PAIR_HL) nxt.hl = cur.hl + 16'd1;
						if (sel == PAIR_SP) nxt.hl = cur.hl - 16'd1;
					end
					LO_INC_RR: begin
						pair_we  = 1'b1;
						pair_new = pair_val + 16'd1;
					end
					default: begin
						pair_we  = 1'b1;
						pair_new = pair_val - 16'd1;
					end
				endcase
			end else begin
				case (op[1:0])
					R8OP_INC, R8OP_DEC: begin
						if (dst == R8_MEM) begin
							cost  = COST_12;
							kind  = MEM_BYTE;
							addr  = cur.hl;
							wdata = {8'h00, post};
						end else begin
							r8_we  = 1'b1;
							r8_new = post;
						end
						nxt.flags = {(post == 8'h00), op[0], half, cur.flags[FLAG_C]};
					end
					R8OP_LD_N: begin
						pc_n = pc_p2;
						cost = COST_8;
						if (dst == R8_MEM) begin
							cost  = COST_12;
							kind  = MEM_BYTE;
							addr  = cur.hl;
							wdata = {8'h00, instr.imm_lo};
						end else begin
							r8_we  = 1'b1;
							r8_new = instr.imm_lo;
						end
					end
					default: begin
						case (dst)
							ROT_RLCA: begin
								nxt.acc   = {cur.acc[6:0], cur.acc[7]};
								nxt.flags = {3'b000, cur.acc[7]};
							end
							ROT_RRCA: begin
								nxt.acc   = {cur.acc[0], cur.acc[7:1]};
								nxt.flags = {3'b000, cur.acc[0]};
							end
							ROT_RLA: begin
								nxt.acc   = {cur.acc[6:0], cur.flags[FLAG_C]};
								nxt.flags = {3'b000, cur.acc[7]};
							end
							ROT_RRA: begin
								nxt.acc   = {cur.flags[FLAG_C], cur.acc[7:1]};
								nxt.flags = {3'b000, cur.acc[0]};
							end
							ROT_DAA: nxt.acc = cur.acc;
							ROT_CPL: begin
								nxt.acc          = ~cur.acc;
								nxt.flags[FLAG_N] = 1'b1;
								nxt.flags[FLAG_H] = 1'b1;
							end
							ROT_SCF: nxt.flags = {cur.flags[FLAG_Z], 3'b001};
							default: nxt.flags = {cur.flags[FLAG_Z], 2'b00, !cur.flags[FLAG_C]};
						endcase
					end
				endcase
			end

			if (pair_we) begin
				case (sel)
					PAIR_BC: nxt.bc = pair_new;
					PAIR_DE: nxt.de = pair_new;
					PAIR_HL: nxt.hl = pair_new;
					default: nxt.sp = pair_new;
				endcase
			end
			if (r8_we) begin
				case (dst)
					R8_B:    nxt.bc[15:8] = r8_new;
					R8_C:    nxt.bc[7:0]  = r8_new;
					R8_D:    nxt.de[15:8] = r8_new;
					R8_E:    nxt.de[7:0]  = r8_new;
					R8_H:    nxt.hl[15:8] = r8_new;
					R8_L:    nxt.hl[7:0]  = r8_new;
					R8_A:    nxt.acc      = r8_new;
					default: nxt.acc      = cur.acc;
				endcase
			end
			nxt.pc = pc_n;
		end
	end

	assign result.pc             = nxt.pc;
	assign result.sp             = nxt.sp;
	assign result.acc            = nxt.acc;
	assign result.flags          = nxt.flags;
	assign result.pair_bc        = nxt.bc;
	assign result.pair_de        = nxt.de;
	assign result.pair_hl        = nxt.hl;
	assign result.halted_stop    = nxt.stopped;
	assign result.mem_write_kind = kind;
	assign result.mem_addr       = addr;
	assign result.mem_write_data = wdata;
	assign result.cycle_cost     = cost;

endmodule

// ===== rtl/core/cpu_block0_instruction_step.sv =====
// Top level of the instruction step block: request stage, execute, result register.
// Flow: an accepted request is held in the request register and executed from there once
// the result register is free or being emptied; its result is registered and waits until taken.
// Throughput: one instruction per cycle while results are taken, set by the execute loop
// that reads and writes the architectural registers.
// Reset: clears all architectural registers, the stopped bit and both valid bits.
module cpu_block0_instruction_step
	import cis_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    instr_valid,
	output logic    instr_ready,
	input  instr_t  instr,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	// Request stage
	instr_t      instr_s1;
	logic        valid_s1;

	// Architectural state and result register
	arch_state_t arch_q;
	arch_state_t arch_nxt;
	result_t     exec_result;
	result_t     result_q;
	logic        result_valid_q;

	// Execute whenever the result register is free or is being emptied this cycle
	logic        adv_s1;

	assign adv_s1      = valid_s1 && (!result_valid_q || result_ready);
	// Take a new request whenever the request stage empties or is already empty
	assign instr_ready = !valid_s1 || adv_s1;

	cis_exec u_exec (
		.cur    (arch_q),
		.instr  (instr_s1),
		.nxt    (arch_nxt),
		.result (exec_result)
	);

	// Control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
			arch_q         <= '0;
		end else begin
			if (instr_ready) begin
				valid_s1 <= instr_valid;
			end
			if (adv_s1) begin
				// commit the instruction and present its result
				arch_q         <= arch_nxt;
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				// drop the result once it has been taken
				result_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (instr_valid && instr_ready) begin
			instr_s1 <= instr;
		end
		if (adv_s1) begin
			result_q <= exec_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Once stopped, the core stays stopped
	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		arch_q.stopped |=> arch_q.stopped)
		else $error("stopped bit cleared");

	// Architectural state moves only when an instruction executes
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(arch_q))
		else $error("architectural state changed without an instruction");

	// A result reports the state it committed
	a_result_pc: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> (result_q.pc == arch_q.pc) && (result_q.pair_hl == arch_q.hl))
		else $error("result does not match committed state");

	// A request while stopped has no cost and no memory access
	a_stopped_idle: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && arch_q.stopped |=> (result_q.cycle_cost == COST_0)
			&& (result_q.mem_write_kind == MEM_NONE))
		else $error("stopped core reported work");

	// Back-pressure on requests only when both stages are full
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!instr_ready |-> valid_s1 && result_valid_q && !result_ready)
		else $error("request stalled while a stage was free");

endmodule
